@@ rtl/mtep_pkg.sv @@
// Package with shared types and constants of the MIDI track event parser.
`timescale 1ns / 1ps
package mtep_pkg;

	typedef enum logic [2:0] {
		PH_DELTA  = 3'd0,
		PH_STATUS = 3'd1,
		PH_DATA1  = 3'd2,
		PH_DATA2  = 3'd3,
		PH_LEN    = 3'd4,
		PH_MTYPE  = 3'd5,
		PH_BODY   = 3'd6,
		PH_DONE   = 3'd7
	} phase_t;

	localparam logic [2:0] KIND_CHANNEL   = 3'd0;
	localparam logic [2:0] KIND_SYSEX     = 3'd1;
	localparam logic [2:0] KIND_SEQUENCER = 3'd2;
	localparam logic [2:0] KIND_TEMPO     = 3'd3;
	localparam logic [2:0] KIND_END       = 3'd4;
	localparam logic [2:0] KIND_ERROR     = 3'd5;

	localparam logic [7:0] ST_SYSEX  = 8'hf0;
	localparam logic [7:0] ST_ESCAPE = 8'hf7;
	localparam logic [7:0] ST_META   = 8'hff;
	localparam logic [7:0] META_END  = 8'h2f;
	localparam logic [7:0] META_SEQ  = 8'h7f;
	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [7:0] META_PREFIX = 8'h20;
	localparam logic [7:0] NO_PREFIX = 8'hff;

	// Upper status nibbles with special handling.
	localparam logic [3:0] NIB_PROGRAM  = 4'hc;
	localparam logic [3:0] NIB_PRESSURE = 4'hd;
	localparam logic [3:0] NIB_BEND     = 4'he;
	localparam logic [3:0] NIB_SYSTEM   = 4'hf;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;

	// Input transaction as classified by the front end.
	typedef struct packed {
		logic       restart;
		logic [7:0] data_byte;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  status_nibble;
		logic [3:0]  channel;
		logic [31:0] value;
		logic [7:0]  second_data;
		logic [47:0] event_tick;
		logic [7:0]  prefix_channel;
	} result_t;

endpackage

@@ rtl/midi_track_event_parser.sv @@
// Top level of the MIDI track event parser.
`timescale 1ns / 1ps
// Parses a MIDI track chunk body one byte per transaction and emits channel
// messages, sysex, sequencer, tempo, track-end and error results. A byte is
// taken every cycle as long as results are drained; a four-entry queue sits
// between the input and the parser, so a result passes through the queue and
// then the parser's output register before it is offered. Write track_length
// only while idle.
module midi_track_event_parser
	import mtep_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tuser,   // restart
	output logic         m_tvalid,
	input  logic         m_tready,
	// status_nibble, channel, value, second_data, event_tick, prefix_channel
	output logic [103:0] m_tdata,
	output logic [2:0]   m_tuser    // kind
);

	logic [31:0] track_length_q;
	item_t       q_in;
	item_t       q_out;
	logic        q_valid;
	logic        q_ready;
	result_t     res;

	assign cfg_ready = 1'b1;

	// Track length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_length_q <= '0;
		end else if (cfg_valid) begin
			track_length_q <= cfg_data;
		end
	end

	assign q_in.restart   = s_tuser;
	assign q_in.data_byte = s_tdata;

	mtep_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_tvalid),
		.wr_ready (s_tready),
		.wr_item  (q_in),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_out)
	);

	mtep_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.track_length (track_length_q),
		.in_valid     (q_valid),
		.in_ready     (q_ready),
		.in_item      (q_out),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_res      (res)
	);

	assign m_tdata = {res.prefix_channel, res.event_tick, res.second_data, res.value,
		res.channel, res.status_nibble};
	assign m_tuser = res.kind;

	// A result never shows an out-of-range kind.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= KIND_ERROR))
		else $error("bad result kind");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser) && $stable(m_tdata))
		else $error("result changed under stall");

	// Non-channel results carry no status nibbles.
	a_nib: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_CHANNEL |-> m_tdata[7:0] == 8'd0)
		else $error("status on non-channel result");

endmodule

@@ rtl/mtep_queue.sv @@
// Short first-in first-out queue of input items between front and back end.
`timescale 1ns / 1ps
module mtep_queue
	import mtep_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  item_t wr_item,
	output logic  rd_valid,
	input  logic  rd_ready,
	output item_t rd_item
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Storage is payload only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/mtep_engine.sv @@
// Back end: parser state machine that turns track bytes into result items.
`timescale 1ns / 1ps
module mtep_engine
	import mtep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] track_length,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  running_q, running_d;
	logic [7:0]  cur_q, cur_d;
	logic [7:0]  meta_q, meta_d;
	logic [31:0] acc_q, acc_d;
	logic [31:0] blen_q, blen_d;
	logic [31:0] bleft_q, bleft_d;
	logic [31:0] used_q, used_d;
	logic [47:0] tick_q, tick_d;
	logic [7:0]  first_q, first_d;
	logic [23:0] tempo_q, tempo_d;
	logic [7:0]  prefix_q, prefix_d;
	logic        have;
	result_t     res;
	logic        out_valid_q;
	result_t     out_q;
	logic        take;

	// Output register; a new item is taken whenever that register is free or leaving.
	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Next state of the parser for one byte.
	always_comb begin
		logic [7:0]  b;
		logic [7:0]  st;
		logic [31:0] nacc;
		logic [31:0] left;
		logic [31:0] used1;
		logic [31:0] bl1;
		logic        isdata;
		logic        do_len;
		logic        do_d1;
		logic        fail;
		phase_d  = phase_q;
		running_d = running_q;
		cur_d    = cur_q;
		meta_d   = meta_q;
		acc_d    = acc_q;
		blen_d   = blen_q;
		bleft_d  = bleft_q;
		used_d   = used_q;
		tick_d   = tick_q;
		first_d  = first_q;
		tempo_d  = tempo_q;
		prefix_d = prefix_q;
		have     = 1'b0;
		res      = '0;
		fail     = 1'b0;
		do_len   = 1'b0;
		do_d1    = 1'b0;
		b        = in_item.data_byte;
		st       = b;
		isdata   = !b[7];
		used1    = used_q + 32'd1;
		left     = (track_length > used1) ? track_length - used1 : 32'd0;
		nacc     = {acc_q[24:0], b[6:0]};
		bl1      = bleft_q - 32'd1;
		if (in_item.restart) begin
			phase_d   = PH_DELTA;
			running_d = '0;
			cur_d     = '0;
			meta_d    = '0;
			acc_d     = '0;
			blen_d    = '0;
			bleft_d   = '0;
			used_d    = '0;
			tick_d    = '0;
			first_d   = '0;
			tempo_d   = '0;
			prefix_d  = NO_PREFIX;
		end else if (phase_q != PH_DONE && used_q < track_length) begin
			used_d = used1;
			case (phase_q)
				PH_DELTA: begin
					acc_d = nacc;
					if (!b[7]) begin
						tick_d  = tick_q + {16'd0, nacc};
						acc_d   = '0;
						phase_d = PH_STATUS;
					end
				end
				PH_STATUS: begin
					if (isdata) begin
						st = running_q;
					end else begin
						running_d = b;
					end
					if (isdata && !running_q[7]) begin
						fail = 1'b1;
					end else if (st == ST_SYSEX || st == ST_ESCAPE) begin
						cur_d   = st;
						acc_d   = '0;
						phase_d = PH_LEN;
						if (isdata) begin
							do_len = 1'b1;
							nacc   = {25'd0, b[6:0]};
						end
					end else if (st == ST_META) begin
						cur_d   = st;
						phase_d = PH_MTYPE;
						if (isdata) begin
							meta_d  = b;
							acc_d   = '0;
							phase_d = PH_LEN;
						end
					end else if (st[7:4] == NIB_SYSTEM) begin
						fail = 1'b1;
					end else begin
						cur_d   = st;
						phase_d = PH_DATA1;
						do_d1   = isdata;
					end
				end
				PH_DATA1: do_d1 = 1'b1;
				PH_DATA2: begin
					have = 1'b1;
					res.kind = KIND_CHANNEL;
					res.status_nibble = cur_q[7:4];
					res.channel = cur_q[3:0];
					if (cur_q[7:4] == NIB_BEND) begin
						res.value = {18'd0, b[6:0], first_q[6:0]};
					end else begin
						res.value = {24'd0, first_q};
						res.second_data = b;
					end
					phase_d = PH_DELTA;
				end
				PH_LEN: do_len = 1'b1;
				PH_MTYPE: begin
					meta_d  = b;
					acc_d   = '0;
					phase_d = PH_LEN;
				end
				PH_BODY: begin
					bleft_d = bl1;
					if (cur_q == ST_META && meta_q == META_TEMPO && blen_q == 32'd3) begin
						tempo_d = {tempo_q[15:0], b};
					end
					if (cur_q == ST_META && meta_q == META_PREFIX && blen_q == 32'd1) begin
						prefix_d = (b < 8'd16) ? b : NO_PREFIX;
					end
					if (bl1 == '0) begin
						phase_d = PH_DELTA;
						if (cur_q == ST_SYSEX) begin
							if (blen_q > 32'd1 && b == ST_ESCAPE) begin
								have      = 1'b1;
								res.kind  = KIND_SYSEX;
								res.value = blen_q - 32'd1;
							end
						end else if (cur_q == ST_META && meta_q == META_TEMPO
								&& blen_q == 32'd3) begin
							have      = 1'b1;
							res.kind  = KIND_TEMPO;
							res.value = {8'd0, tempo_q[15:0], b};
						end
					end
				end
				default: phase_d = PH_DONE;
			endcase
			// Length byte, shared by the length phase and a running-status sysex.
			if (do_len) begin
				acc_d = nacc;
				if (!b[7]) begin
					acc_d   = '0;
					blen_d  = nacc;
					bleft_d = nacc;
					tempo_d = '0;
					if (nacc > left || (cur_d != ST_META && nacc == '0)) begin
						fail = 1'b1;
					end else if (cur_d == ST_META && meta_d == META_END) begin
						have     = 1'b1;
						res.kind = KIND_END;
						phase_d  = PH_DONE;
					end else begin
						if (cur_d == ST_META && meta_d == META_SEQ) begin
							have      = 1'b1;
							res.kind  = KIND_SEQUENCER;
							res.value = (nacc != '0) ? nacc - 32'd1 : 32'd0;
						end
						phase_d = (nacc != '0) ? PH_BODY : PH_DELTA;
					end
				end
			end
			// First data byte of a channel message.
			if (do_d1) begin
				first_d = b;
				if (cur_d[7:4] == NIB_PROGRAM || cur_d[7:4] == NIB_PRESSURE) begin
					have              = 1'b1;
					res.kind          = KIND_CHANNEL;
					res.status_nibble = cur_d[7:4];
					res.channel       = cur_d[3:0];
					res.value         = {24'd0, b};
					phase_d           = PH_DELTA;
				end else begin
					phase_d = PH_DATA2;
				end
			end
			if (fail) begin
				have    = 1'b1;
				res     = '0;
				res.kind = KIND_ERROR;
				phase_d = PH_DONE;
			end
			// End of the track body.
			if (phase_d != PH_DONE && used1 >= track_length) begin
				if (phase_d != PH_DELTA && phase_d != PH_STATUS && !have) begin
					have     = 1'b1;
					res      = '0;
					res.kind = KIND_ERROR;
				end
				phase_d = PH_DONE;
			end
			res.event_tick     = tick_d;
			res.prefix_channel = prefix_d;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DELTA;
			running_q   <= '0;
			cur_q       <= '0;
			meta_q      <= '0;
			acc_q       <= '0;
			blen_q      <= '0;
			bleft_q     <= '0;
			used_q      <= '0;
			tick_q      <= '0;
			first_q     <= '0;
			tempo_q     <= '0;
			prefix_q    <= NO_PREFIX;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q   <= phase_d;
				running_q <= running_d;
				cur_q     <= cur_d;
				meta_q    <= meta_d;
				acc_q     <= acc_d;
				blen_q    <= blen_d;
				bleft_q   <= bleft_d;
				used_q    <= used_d;
				tick_q    <= tick_d;
				first_q   <= first_d;
				tempo_q   <= tempo_d;
				prefix_q  <= prefix_d;
			end
			if (in_ready) begin
				out_valid_q <= take && have;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (take && have) begin
			out_q <= res;
		end
	end

endmodule
